[rtl/ilvc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ilvc_pkg;

   localparam int CpWidth = 21;
   localparam int BcWidth = 5;
   localparam int RsnWidth = 3;

   localparam logic [CpWidth-1:0] ZwnjCp = 21'h0200c;
   localparam logic [CpWidth-1:0] ZwjCp  = 21'h0200d;

   localparam logic [BcWidth-1:0] BcBn  = 5'd1;
   localparam logic [BcWidth-1:0] BcCs  = 5'd2;
   localparam logic [BcWidth-1:0] BcEs  = 5'd3;
   localparam logic [BcWidth-1:0] BcOn  = 5'd4;
   localparam logic [BcWidth-1:0] BcEn  = 5'd5;
   localparam logic [BcWidth-1:0] BcL   = 5'd6;
   localparam logic [BcWidth-1:0] BcR   = 5'd7;
   localparam logic [BcWidth-1:0] BcNsm = 5'd8;
   localparam logic [BcWidth-1:0] BcAl  = 5'd9;
   localparam logic [BcWidth-1:0] BcAn  = 5'd10;
   localparam logic [BcWidth-1:0] BcEt  = 5'd11;

   localparam logic [1:0] JvUndecided = 2'd0;
   localparam logic [1:0] JvPass      = 2'd1;
   localparam logic [1:0] JvFail      = 2'd2;
   localparam logic [1:0] JvWaitRight = 2'd3;

   localparam logic [RsnWidth-1:0] RsnNone    = 3'd0;
   localparam logic [RsnWidth-1:0] RsnLeadCmb = 3'd1;
   localparam logic [RsnWidth-1:0] RsnJoiner  = 3'd2;
   localparam logic [RsnWidth-1:0] RsnOnlyNsm = 3'd3;
   localparam logic [RsnWidth-1:0] RsnBidi    = 3'd4;

   // character properties from the rom lookup
   typedef struct packed {
      logic virama;
      logic left_or_dual;
      logic right_or_dual;
      logic zwnj;
      logic zwj;
   } cp_props_type;

   // per-label running state
   typedef struct packed {
      logic               at_start;
      logic               lead_cmb;
      logic [BcWidth-1:0] lead_class;
      logic [1:0]         jv;
      logic               prev_virama;
      logic               seen_lod;
      logic               rtl_present;
      logic               ltr_broken;
      logic               rtl_broken;
      logic               en_seen;
      logic               an_seen;
      logic [BcWidth-1:0] tail_class;
      logic               any_non_nsm;
   } lbl_state_type;

   function automatic logic is_virama(input logic [CpWidth-1:0] c);
      case (c)
         21'h094D, 21'h09CD, 21'h0A4D, 21'h0ACD, 21'h0B4D, 21'h0BCD, 21'h0C4D,
         21'h0CCD, 21'h0D3B, 21'h0D3C, 21'h0D4D, 21'h0DCA, 21'h0E3A, 21'h0EBA,
         21'h0F84, 21'h1039, 21'h103A, 21'h1714, 21'h1734, 21'h17D2, 21'h1A60,
         21'h1B44, 21'h1BAA, 21'h1BAB, 21'h1BF2, 21'h1BF3, 21'h2D7F, 21'hA806,
         21'hA82C, 21'hA8C4, 21'hA953, 21'hA9C0, 21'hAAF6, 21'hABED, 21'h10A3F,
         21'h11046, 21'h1107F, 21'h110B9, 21'h11133, 21'h11134, 21'h111C0,
         21'h11235, 21'h112EA, 21'h1134D, 21'h11442, 21'h114C2, 21'h115BF,
         21'h1163F, 21'h116B6, 21'h1172B, 21'h11839, 21'h1193D, 21'h1193E,
         21'h119E0, 21'h11A34, 21'h11A47, 21'h11A99, 21'h11C3F, 21'h11D44,
         21'h11D45, 21'h11D97: is_virama = 1'b1;
         default: is_virama = 1'b0;
      endcase
   endfunction

   function automatic logic is_right(input logic [CpWidth-1:0] c);
      case (c)
         21'h622, 21'h623, 21'h624, 21'h625, 21'h627, 21'h629, 21'h62f, 21'h630,
         21'h631, 21'h632, 21'h648, 21'h671, 21'h672, 21'h673, 21'h675, 21'h676,
         21'h677, 21'h688, 21'h689, 21'h68a, 21'h68b, 21'h68c, 21'h68d, 21'h68e,
         21'h68f, 21'h690, 21'h691, 21'h692, 21'h693, 21'h694, 21'h695, 21'h696,
         21'h697, 21'h698, 21'h699, 21'h6c0, 21'h6c3, 21'h6c4, 21'h6c5, 21'h6c6,
         21'h6c7, 21'h6c8, 21'h6c9, 21'h6ca, 21'h6cb, 21'h6cd, 21'h6cf, 21'h6d2,
         21'h6d3, 21'h6d5, 21'h6ee, 21'h6ef, 21'h710, 21'h715, 21'h716, 21'h717,
         21'h718, 21'h719, 21'h71e, 21'h728, 21'h72a, 21'h72c, 21'h72f, 21'h74d,
         21'h759, 21'h75a, 21'h75b, 21'h854, 21'h8aa, 21'h8ab, 21'h8ac:
            is_right = 1'b1;
         default: is_right = 1'b0;
      endcase
   endfunction

   function automatic logic is_dual(input logic [CpWidth-1:0] c);
      logic s;
      case (c)
         21'h620, 21'h626, 21'h628, 21'h62a, 21'h62b, 21'h62c, 21'h62d, 21'h62e,
         21'h649, 21'h64a, 21'h66e, 21'h66f, 21'h6c1, 21'h6c2, 21'h6cc, 21'h6ce,
         21'h6d0, 21'h6d1, 21'h6fa, 21'h6fb, 21'h6fc, 21'h6ff, 21'h712, 21'h713,
         21'h714, 21'h729, 21'h72b, 21'h72d, 21'h72e, 21'h74e, 21'h74f, 21'h855,
         21'h8a0, 21'h1807, 21'h18aa: s = 1'b1;
         default: s = 1'b0;
      endcase
      is_dual = s
         || (c >= 21'h633 && c <= 21'h63f) || (c >= 21'h641 && c <= 21'h647)
         || (c >= 21'h678 && c <= 21'h687) || (c >= 21'h69a && c <= 21'h6bf)
         || (c >= 21'h71a && c <= 21'h71d) || (c >= 21'h71f && c <= 21'h727)
         || (c >= 21'h750 && c <= 21'h758) || (c >= 21'h75c && c <= 21'h766)
         || (c >= 21'h850 && c <= 21'h853) || (c >= 21'h8a2 && c <= 21'h8a9)
         || (c >= 21'h1820 && c <= 21'h1877) || (c >= 21'h1887 && c <= 21'h18a8)
         || (c >= 21'hA840 && c <= 21'hA871);
   endfunction

endpackage
`default_nettype wire

[rtl/ilvc_cp_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none
module ilvc_cp_lookup (
   input  wire logic [ilvc_pkg::CpWidth-1:0] char_cp,
   output ilvc_pkg::cp_props_type            props
);
   logic dual;

   assign dual = ilvc_pkg::is_dual(char_cp);

   always_comb begin
      props.virama        = ilvc_pkg::is_virama(char_cp);
      props.left_or_dual  = dual || (char_cp == 21'hA872);
      props.right_or_dual = dual || ilvc_pkg::is_right(char_cp);
      props.zwnj          = char_cp == ilvc_pkg::ZwnjCp;
      props.zwj           = char_cp == ilvc_pkg::ZwjCp;
   end
endmodule
`default_nettype wire

[rtl/ilvc_label_state.sv]
`timescale 1ns / 1ps
`default_nettype none
module ilvc_label_state (
   input  wire ilvc_pkg::lbl_state_type                cur,
   input  wire ilvc_pkg::cp_props_type                 props,
   input  wire logic [ilvc_pkg::BcWidth-1:0]           bidi_class,
   input  wire logic                                   is_combining,
   input  wire logic                                   last_in_label,
   output ilvc_pkg::lbl_state_type                     nxt,
   output logic                                        label_valid,
   output logic [ilvc_pkg::RsnWidth-1:0]               fail_reason
);
   logic first, in_ltr, in_rtl_only, is_mark, bidi_ok;
   logic [ilvc_pkg::BcWidth-1:0] fd, ld;

   always_comb begin
      first = cur.at_start;
      nxt = cur;
      if (first) begin
         nxt.lead_cmb   = is_combining;
         nxt.lead_class = bidi_class;
      end
      unique case (cur.jv)
         ilvc_pkg::JvWaitRight: begin
            if (props.right_or_dual) nxt.jv = ilvc_pkg::JvPass;
         end
         ilvc_pkg::JvUndecided: begin
            if (props.zwnj) begin
               if (!first && cur.prev_virama) nxt.jv = ilvc_pkg::JvPass;
               else if (first || last_in_label) nxt.jv = ilvc_pkg::JvFail;
               else nxt.jv = cur.seen_lod ? ilvc_pkg::JvWaitRight : ilvc_pkg::JvFail;
            end else if (props.zwj) begin
               nxt.jv = (!first && cur.prev_virama) ? ilvc_pkg::JvPass : ilvc_pkg::JvFail;
            end
         end
         default: ;
      endcase
      if (props.left_or_dual) nxt.seen_lod = 1'b1;
      nxt.prev_virama = props.virama;

      case (bidi_class)
         ilvc_pkg::BcL, ilvc_pkg::BcEn, ilvc_pkg::BcEs, ilvc_pkg::BcCs,
         ilvc_pkg::BcEt, ilvc_pkg::BcOn, ilvc_pkg::BcBn, ilvc_pkg::BcNsm:
            in_ltr = 1'b1;
         default: in_ltr = 1'b0;
      endcase
      is_mark = bidi_class == ilvc_pkg::BcR || bidi_class == ilvc_pkg::BcAl
         || bidi_class == ilvc_pkg::BcAn;
      in_rtl_only = is_mark || (in_ltr && bidi_class != ilvc_pkg::BcL);
      if (is_mark) nxt.rtl_present = 1'b1;
      if (!in_ltr) nxt.ltr_broken = 1'b1;
      if (!in_rtl_only) nxt.rtl_broken = 1'b1;
      if (bidi_class == ilvc_pkg::BcEn) nxt.en_seen = 1'b1;
      if (bidi_class == ilvc_pkg::BcAn) nxt.an_seen = 1'b1;
      if (bidi_class != ilvc_pkg::BcNsm) begin
         nxt.tail_class = bidi_class;
         nxt.any_non_nsm = 1'b1;
      end
      nxt.at_start = 1'b0;

      // verdict from the updated flags
      fd = nxt.lead_class;
      ld = nxt.tail_class;
      if (!nxt.rtl_present) bidi_ok = 1'b1;
      else if (fd == ilvc_pkg::BcL)
         bidi_ok = !nxt.ltr_broken && (ld == ilvc_pkg::BcL || ld == ilvc_pkg::BcEn);
      else if (fd != ilvc_pkg::BcR && fd != ilvc_pkg::BcAl) bidi_ok = 1'b0;
      else if (nxt.rtl_broken) bidi_ok = 1'b0;
      else if (nxt.en_seen && nxt.an_seen) bidi_ok = 1'b0;
      else bidi_ok = ld == ilvc_pkg::BcR || ld == ilvc_pkg::BcAl
         || ld == ilvc_pkg::BcAn || ld == ilvc_pkg::BcEn;

      label_valid = 1'b1;
      fail_reason = ilvc_pkg::RsnNone;
      if (nxt.lead_cmb) begin
         label_valid = 1'b0; fail_reason = ilvc_pkg::RsnLeadCmb;
      end else if (nxt.jv == ilvc_pkg::JvPass) begin
         label_valid = 1'b1;
      end else if (nxt.jv != ilvc_pkg::JvUndecided) begin
         label_valid = 1'b0; fail_reason = ilvc_pkg::RsnJoiner;
      end else if (!nxt.any_non_nsm) begin
         label_valid = 1'b0; fail_reason = ilvc_pkg::RsnOnlyNsm;
      end else if (!bidi_ok) begin
         label_valid = 1'b0; fail_reason = ilvc_pkg::RsnBidi;
      end
   end
endmodule
`default_nettype wire

[rtl/idna_label_validity_check_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Checks one idna label, one code point per transfer, with bidi class and
// combining flag supplied upstream. Input transfers are registered, then
// rom lookups and the flag update run combinationally into the label state
// and an output register; a verdict transfer comes out only for the code
// point marked last, from the output register once that code point has left
// the input register. Throughput is one code point per cycle; the input
// stalls only when the output register is full and the result side is
// stalling.
module idna_label_validity_check_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [ilvc_pkg::CpWidth-1:0]     req_code_point,
   input  wire logic [ilvc_pkg::BcWidth-1:0]     req_bidi_class,
   input  wire logic                             req_is_combining,
   input  wire logic                             req_last_in_label,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_label_valid,
   output logic [ilvc_pkg::RsnWidth-1:0]         rsp_fail_reason
);
   logic                          in_vld_ff;
   logic [ilvc_pkg::CpWidth-1:0]  cp_ff;
   logic [ilvc_pkg::BcWidth-1:0]  bc_ff;
   logic                          cmb_ff, last_ff;
   ilvc_pkg::lbl_state_type       st_ff, st_in, st_nxt, st_reset;
   ilvc_pkg::cp_props_type        props;
   logic                          v_in;
   logic [ilvc_pkg::RsnWidth-1:0] r_in;
   logic                          out_vld_ff, out_vld_in, lv_ff;
   logic [ilvc_pkg::RsnWidth-1:0] rsn_ff;
   logic                          advance, req_xfer;

   always_comb begin
      st_reset = '0;
      st_reset.at_start = 1'b1;
   end

   // stage 1 moves whenever the output slot is free or draining
   assign advance  = !out_vld_ff || !rsp_stall;
   assign req_stall = !advance;
   assign req_xfer = req_valid && advance;

   ilvc_cp_lookup u_lookup (.char_cp(cp_ff), .props(props));

   ilvc_label_state u_state (
      .cur(st_ff), .props(props), .bidi_class(bc_ff), .is_combining(cmb_ff),
      .last_in_label(last_ff), .nxt(st_nxt), .label_valid(v_in),
      .fail_reason(r_in)
   );

   always_comb begin
      st_in = st_ff;
      out_vld_in = out_vld_ff && rsp_stall;
      if (in_vld_ff && advance) begin
         st_in = last_ff ? st_reset : st_nxt;
         out_vld_in = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         st_ff      <= st_reset;
      end else begin
         if (advance) in_vld_ff <= req_valid;
         out_vld_ff <= out_vld_in;
         st_ff      <= st_in;
      end
      if (req_xfer) begin
         cp_ff   <= req_code_point;
         bc_ff   <= req_bidi_class;
         cmb_ff  <= req_is_combining;
         last_ff <= req_last_in_label;
      end
      if (in_vld_ff && advance && last_ff) begin
         lv_ff  <= v_in;
         rsn_ff <= r_in;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_label_valid = lv_ff;
   assign rsp_fail_reason = rsn_ff;

   a_valid_means_zero_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_label_valid == (rsp_fail_reason == ilvc_pkg::RsnNone)))
      else $error("verdict and reason disagree");
   a_state_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && advance && last_ff) |=> st_ff.at_start)
      else $error("label state not cleared after last code point");
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_vld_ff && rsp_stall))
      else $error("input stalled without a waiting result");
endmodule
`default_nettype wire
